/* sv/dtvm_pkg.sv */
// ----------------------------------------------------------------------------
// dtvm_pkg
// Shared types, constants and the sine table function for the voice mixer.
// ----------------------------------------------------------------------------
package dtvm_pkg;

	localparam int PHASE_BITS_DEF      = 24;
	localparam int SINE_INDEX_BITS_DEF = 10;
	localparam int LEVEL_FRAC_BITS_DEF = 23;
	localparam int SAMPLE_HZ_DEF       = 44100;

	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_KICK_DECAY    = 3'd0,
		REG_SNARE_DECAY   = 3'd1,
		REG_HAT_DECAY     = 3'd2,
		REG_RELEASE_DECAY = 3'd3,
		REG_TONE_GAIN     = 3'd4,
		REG_KICK_GAIN     = 3'd5,
		REG_SNARE_GAIN    = 3'd6,
		REG_HAT_GAIN      = 3'd7
	} reg_idx_t;

	localparam logic [15:0] KICK_DECAY_RST    = 16'd59;
	localparam logic [15:0] SNARE_DECAY_RST   = 16'd262;
	localparam logic [15:0] HAT_DECAY_RST     = 16'd1311;
	localparam logic [15:0] RELEASE_DECAY_RST = 16'd262;
	localparam logic [14:0] TONE_GAIN_RST     = 15'd8000;
	localparam logic [14:0] KICK_GAIN_RST     = 15'd12000;
	localparam logic [14:0] SNARE_GAIN_RST    = 15'd8000;
	localparam logic [14:0] HAT_GAIN_RST      = 15'd4000;
	localparam logic [14:0] SNARE_BODY_GAIN   = 15'd3000;
	localparam logic [15:0] NOISE_SEED        = 16'hACE1;
	localparam logic [15:0] NOISE_TAPS        = 16'hB400;

	// voice slots, in mixing order
	typedef enum logic [2:0] {
		V_TONE, V_KICK, V_SNARE_N, V_SNARE_B, V_HAT
	} voice_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_MUL1, ST_MUL2, ST_ACC, ST_UPD, ST_OUT
	} state_t;

	typedef struct packed {
		logic   start;     // latch request, apply triggers
		logic   load;      // select operands for current voice
		logic   mul1;      // sample * level
		logic   mul2;      // * gain
		logic   acc;       // add to sum
		logic   upd;       // advance phase, decay level
		logic   finish;    // saturate into output register
		voice_t voice;
	} dp_cmd_t;

	typedef struct packed {
		logic active;      // current voice sounds this tick
	} dp_sts_t;

	// Quarter-wave sine magnitude for table slot q, Q1.15, from the fixed-point
	// Taylor series; only evaluated on constants to fill the lookup table
	function automatic logic [15:0] sine_mag(input int q, input int ib);
		logic [63:0] x, x2, t, v;
		x = (64'(q) * 64'd6746518852) >> ib;
		x2 = (x * x) >> 30;
		t = 64'd1073741824 - x2 / 64'd110;
		t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd72;
		t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
		t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
		t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
		v = (((x * t) >> 30) + 64'd16384) >> 15;
		if (v > 64'd32767) v = 64'd32767;
		return v[15:0];
	endfunction

endpackage

/* sv/dtvm_if.sv */
// ----------------------------------------------------------------------------
// dtvm channel interfaces
// Valid/ready request channels for input ticks, results and configuration.
// ----------------------------------------------------------------------------
interface dtvm_in_if;
	logic        valid;
	logic        ready;
	logic        tone_on;
	logic [22:0] tone_step;
	logic        kick_trigger;
	logic        snare_trigger;
	logic        hat_trigger;
	modport source (output valid, tone_on, tone_step, kick_trigger, snare_trigger,
		hat_trigger, input ready);
	modport sink (input valid, tone_on, tone_step, kick_trigger, snare_trigger,
		hat_trigger, output ready);
endinterface

interface dtvm_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] mixed_sample;
	logic [3:0]         voices_active;
	modport source (output valid, mixed_sample, voices_active, input ready);
	modport sink (input valid, mixed_sample, voices_active, output ready);
endinterface

interface dtvm_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* sv/dtvm_ctrl.sv */
// ----------------------------------------------------------------------------
// dtvm_ctrl
// Sequencer: walks the five voice slots through the shared multiplier.
// ----------------------------------------------------------------------------
module dtvm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  dtvm_pkg::dp_sts_t sts,
	output dtvm_pkg::dp_cmd_t cmd
);
	import dtvm_pkg::*;

	state_t state_q, state_d;
	voice_t voice_q, voice_d;
	logic   ovalid_q, ovalid_d;

	always_comb begin
		state_d = state_q;
		voice_d = voice_q;
		unique case (state_q)
			ST_IDLE: if (in_valid && !ovalid_q) begin
				state_d = ST_LOAD;
				voice_d = V_TONE;
			end
			ST_LOAD: state_d = sts.active ? ST_MUL1 : ST_UPD;
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_ACC;
			ST_ACC:  state_d = ST_UPD;
			ST_UPD: begin
				if (voice_q == V_HAT) state_d = ST_OUT;
				else begin
					voice_d = voice_t'(voice_q + 3'd1);
					state_d = ST_LOAD;
				end
			end
			ST_OUT:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.voice = voice_q;
		unique case (state_q)
			ST_IDLE: cmd.start = in_valid && !ovalid_q;
			ST_LOAD: cmd.load = 1'b1;
			ST_MUL1: cmd.mul1 = 1'b1;
			ST_MUL2: cmd.mul2 = 1'b1;
			ST_ACC:  cmd.acc = 1'b1;
			ST_UPD:  cmd.upd = 1'b1;
			ST_OUT:  cmd.finish = 1'b1;
			default: ;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE) && !ovalid_q;
	assign out_valid = ovalid_q;
	assign ovalid_d = cmd.finish ? 1'b1 : (out_ready ? 1'b0 : ovalid_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			voice_q  <= V_TONE;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			voice_q  <= voice_d;
			ovalid_q <= ovalid_d;
		end
	end
endmodule

/* sv/dtvm_dp.sv */
// ----------------------------------------------------------------------------
// dtvm_dp
// Voice state, configuration registers, shared multiplier and mix accumulator.
// ----------------------------------------------------------------------------
module dtvm_dp #(
	parameter int PHASE_BITS      = dtvm_pkg::PHASE_BITS_DEF,
	parameter int SINE_INDEX_BITS = dtvm_pkg::SINE_INDEX_BITS_DEF,
	parameter int LEVEL_FRAC_BITS = dtvm_pkg::LEVEL_FRAC_BITS_DEF,
	parameter int SAMPLE_HZ       = dtvm_pkg::SAMPLE_HZ_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dtvm_pkg::dp_cmd_t cmd,
	output dtvm_pkg::dp_sts_t sts,
	input  logic              tone_on,
	input  logic [22:0]       tone_step,
	input  logic              kick_trigger,
	input  logic              snare_trigger,
	input  logic              hat_trigger,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output logic signed [15:0] mixed_sample,
	output logic [3:0]        voices_active
);
	import dtvm_pkg::*;

	localparam int LB = LEVEL_FRAC_BITS + 1;
	localparam logic [LB-1:0] LEVEL_ONE = LB'(64'd1 << LEVEL_FRAC_BITS);
	localparam logic [LB-1:0] TONE_FLOOR =
		LB'(((64'd1 << LEVEL_FRAC_BITS) * 64'd5 + 64'd5000) / 64'd10000);
	localparam logic [LB-1:0] DRUM_FLOOR =
		LB'(((64'd1 << LEVEL_FRAC_BITS) + 64'd5000) / 64'd10000);
	localparam logic [PHASE_BITS-1:0] KICK_STEP =
		PHASE_BITS'(((64'd40 << PHASE_BITS) + 64'(SAMPLE_HZ / 2)) / 64'(SAMPLE_HZ));
	localparam logic [PHASE_BITS-1:0] SNARE_STEP =
		PHASE_BITS'(((64'd180 << PHASE_BITS) + 64'(SAMPLE_HZ / 2)) / 64'(SAMPLE_HZ));
	localparam int SHIFT = 15 + LEVEL_FRAC_BITS;
	localparam int AW = LB + 17 + 15 + 3;
	localparam int QB = SINE_INDEX_BITS - 2;
	localparam int QN = 1 << QB;
	localparam logic [15:0] SINE_TOP = sine_mag(QN, SINE_INDEX_BITS);

	logic [15:0] kick_decay_q, snare_decay_q, hat_decay_q, release_decay_q;
	logic [14:0] tone_gain_q, kick_gain_q, snare_gain_q, hat_gain_q;

	logic [PHASE_BITS-1:0] tone_phase_q, kick_phase_q, snare_phase_q;
	logic [LB-1:0] tone_level_q, kick_level_q, snare_level_q, hat_level_q;
	logic tone_act_q, kick_act_q, snare_act_q, hat_act_q;
	logic [15:0] noise_q;
	logic on_q;
	logic [22:0] step_q;
	logic [3:0] mask_q;

	logic signed [16:0] samp_q;
	logic [LB-1:0] lvl_q;
	logic [14:0] gain_q;
	logic signed [LB+17:0] prod1_q;
	logic signed [AW-1:0] prod2_q, acc_q;

	// operand selection
	logic act_c;
	logic [PHASE_BITS-1:0] ph_c;
	logic [LB-1:0] lv_c;
	logic [14:0] gn_c;
	logic [15:0] dec_c;
	logic [15:0] noise_nx;
	logic is_noise;

	// quarter-wave sine lookup
	logic [15:0] sine_qtr [QN];
	logic [SINE_INDEX_BITS-1:0] sidx;
	logic [1:0] squad;
	logic [QB-1:0] sr, sq;
	logic [15:0] smag;
	logic signed [16:0] sine_c;

	for (genvar g = 0; g < QN; g++) begin : g_sine
		localparam logic [15:0] ENTRY = sine_mag(g, SINE_INDEX_BITS);
		assign sine_qtr[g] = ENTRY;
	end

	assign sidx = ph_c[PHASE_BITS-1 -: SINE_INDEX_BITS];
	assign squad = sidx[SINE_INDEX_BITS-1 -: 2];
	assign sr = sidx[QB-1:0];
	// mirror odd quadrants; the peak slot lies one past the table
	assign sq = squad[0] ? (~sr + QB'(1)) : sr;
	assign smag = (squad[0] && sr == '0) ? SINE_TOP : sine_qtr[sq];
	assign sine_c = squad[1] ? -$signed({1'b0, smag}) : $signed({1'b0, smag});

	assign noise_nx = noise_q[0] ? ((noise_q >> 1) ^ NOISE_TAPS) : (noise_q >> 1);

	always_comb begin
		act_c = 1'b0; ph_c = '0; lv_c = '0; gn_c = '0; dec_c = '0; is_noise = 1'b0;
		case (cmd.voice)
			V_TONE: begin
				act_c = tone_act_q; ph_c = tone_phase_q; lv_c = tone_level_q;
				gn_c = tone_gain_q; dec_c = release_decay_q;
			end
			V_KICK: begin
				act_c = kick_act_q; ph_c = kick_phase_q; lv_c = kick_level_q;
				gn_c = kick_gain_q; dec_c = kick_decay_q;
			end
			V_SNARE_N: begin
				act_c = snare_act_q; lv_c = snare_level_q; gn_c = snare_gain_q;
				is_noise = 1'b1;
			end
			V_SNARE_B: begin
				act_c = snare_act_q; ph_c = snare_phase_q; lv_c = snare_level_q;
				gn_c = SNARE_BODY_GAIN; dec_c = snare_decay_q;
			end
			V_HAT: begin
				act_c = hat_act_q; lv_c = hat_level_q; gn_c = hat_gain_q;
				dec_c = hat_decay_q; is_noise = 1'b1;
			end
			default: ;
		endcase
	end
	assign sts.active = act_c;

	// decay: level - ceil(level * d / 65536)
	logic [LB+15:0] dprod;
	logic [LB-1:0] lv_dec;
	assign dprod = lv_c * dec_c;
	assign lv_dec = lv_c - LB'((dprod + (LB+16)'(16'hFFFF)) >> 16);

	logic [PHASE_BITS+LB-1:0] kprod;
	assign kprod = KICK_STEP * kick_level_q;

	// saturation
	logic neg;
	logic [AW-1:0] mag;
	assign neg = acc_q[AW-1];
	assign mag = (neg ? AW'(-acc_q) : AW'(acc_q)) >> SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kick_decay_q <= KICK_DECAY_RST; snare_decay_q <= SNARE_DECAY_RST;
			hat_decay_q <= HAT_DECAY_RST; release_decay_q <= RELEASE_DECAY_RST;
			tone_gain_q <= TONE_GAIN_RST; kick_gain_q <= KICK_GAIN_RST;
			snare_gain_q <= SNARE_GAIN_RST; hat_gain_q <= HAT_GAIN_RST;
			tone_phase_q <= '0; kick_phase_q <= '0; snare_phase_q <= '0;
			tone_level_q <= '0; kick_level_q <= '0; snare_level_q <= '0; hat_level_q <= '0;
			tone_act_q <= 1'b0; kick_act_q <= 1'b0; snare_act_q <= 1'b0; hat_act_q <= 1'b0;
			noise_q <= NOISE_SEED;
			mask_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_KICK_DECAY:    kick_decay_q <= cfg_data;
					REG_SNARE_DECAY:   snare_decay_q <= cfg_data;
					REG_HAT_DECAY:     hat_decay_q <= cfg_data;
					REG_RELEASE_DECAY: release_decay_q <= cfg_data;
					REG_TONE_GAIN:     tone_gain_q <= cfg_data[14:0];
					REG_KICK_GAIN:     kick_gain_q <= cfg_data[14:0];
					REG_SNARE_GAIN:    snare_gain_q <= cfg_data[14:0];
					REG_HAT_GAIN:      hat_gain_q <= cfg_data[14:0];
					default: ;
				endcase
			end
			if (cmd.start) begin
				mask_q <= '0;
				if (kick_trigger) begin
					kick_act_q <= 1'b1; kick_phase_q <= '0; kick_level_q <= LEVEL_ONE;
				end
				if (snare_trigger) begin
					snare_act_q <= 1'b1; snare_phase_q <= '0; snare_level_q <= LEVEL_ONE;
				end
				if (hat_trigger) begin
					hat_act_q <= 1'b1; hat_level_q <= LEVEL_ONE;
				end
				if (tone_on && !tone_act_q) begin
					tone_act_q <= 1'b1; tone_level_q <= LEVEL_ONE;
				end
			end
			// draw noise when loading an active noise slot
			if (cmd.load && act_c && is_noise) noise_q <= noise_nx;
			if (cmd.upd && act_c) begin
				case (cmd.voice)
					V_TONE: begin
						mask_q[0] <= 1'b1;
						tone_phase_q <= tone_phase_q + PHASE_BITS'(step_q);
						if (!on_q) begin
							tone_level_q <= lv_dec;
							if (lv_dec < TONE_FLOOR) tone_act_q <= 1'b0;
						end
					end
					V_KICK: begin
						mask_q[1] <= 1'b1;
						kick_phase_q <= kick_phase_q + KICK_STEP +
							PHASE_BITS'(kprod >> LEVEL_FRAC_BITS);
						kick_level_q <= lv_dec;
						if (lv_dec < DRUM_FLOOR) kick_act_q <= 1'b0;
					end
					V_SNARE_B: begin
						mask_q[2] <= 1'b1;
						snare_phase_q <= snare_phase_q + SNARE_STEP;
						snare_level_q <= lv_dec;
						if (lv_dec < DRUM_FLOOR) snare_act_q <= 1'b0;
					end
					V_HAT: begin
						mask_q[3] <= 1'b1;
						hat_level_q <= lv_dec;
						if (lv_dec < DRUM_FLOOR) hat_act_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			on_q <= tone_on;
			step_q <= tone_step;
			acc_q <= '0;
		end
		if (cmd.load) begin
			samp_q <= is_noise ? $signed({1'b0, noise_nx}) - 17'sd32768 : sine_c;
			lvl_q <= lv_c;
			gain_q <= gn_c;
		end
		if (cmd.mul1) prod1_q <= samp_q * $signed({1'b0, lvl_q});
		if (cmd.mul2) prod2_q <= AW'(prod1_q) * $signed({1'b0, gain_q});
		if (cmd.acc) acc_q <= acc_q + prod2_q;
		if (cmd.finish) begin
			if (neg) mixed_sample <= (mag > AW'(32768)) ? -16'sd32768 : -$signed(mag[15:0]);
			else mixed_sample <= (mag > AW'(32767)) ? 16'sd32767 : $signed(mag[15:0]);
			voices_active <= mask_q;
		end
	end
endmodule

/* sv/drum_and_tone_voice_mixer_core.sv */
// ----------------------------------------------------------------------------
// drum_and_tone_voice_mixer_core
// Mixes a tone voice and kick, snare and hat drums into one 16-bit sample.
// ----------------------------------------------------------------------------
// One input tick yields one sample. Once the request is taken, each of five
// voice slots (tone, kick, snare noise, snare body, hat) passes through load
// and update when silent, and through load, two multiply steps, accumulate
// and update when sounding; a final step then saturates the sum into the
// result register. The result register holds the sample until taken; the next
// tick is accepted in the cycle after it is gone, so no tick is taken while a
// sample is mixed or waits. Configuration writes are taken in any cycle.
module drum_and_tone_voice_mixer_core #(
	parameter int PHASE_BITS      = dtvm_pkg::PHASE_BITS_DEF,
	parameter int SINE_INDEX_BITS = dtvm_pkg::SINE_INDEX_BITS_DEF,
	parameter int LEVEL_FRAC_BITS = dtvm_pkg::LEVEL_FRAC_BITS_DEF,
	parameter int SAMPLE_HZ       = dtvm_pkg::SAMPLE_HZ_DEF
) (
	input logic       clk,
	input logic       arst_n,
	dtvm_in_if.sink   in_ch,
	dtvm_out_if.source out_ch,
	dtvm_cfg_if.sink  cfg
);
	import dtvm_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg.ready = 1'b1;

	dtvm_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts, .cmd
	);

	dtvm_dp #(
		.PHASE_BITS(PHASE_BITS), .SINE_INDEX_BITS(SINE_INDEX_BITS),
		.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS), .SAMPLE_HZ(SAMPLE_HZ)
	) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.tone_on(in_ch.tone_on), .tone_step(in_ch.tone_step),
		.kick_trigger(in_ch.kick_trigger), .snare_trigger(in_ch.snare_trigger),
		.hat_trigger(in_ch.hat_trigger),
		.cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
		.mixed_sample(out_ch.mixed_sample), .voices_active(out_ch.voices_active)
	);
endmodule

/* sv/dtvm_chk.sv */
// ----------------------------------------------------------------------------
// dtvm_chk
// Port-level checks for the voice mixer, bound to the top level.
// ----------------------------------------------------------------------------
module dtvm_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic signed [15:0] mixed_sample
);
	// no new request while a result waits
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");

	// no result right after a request is taken
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid) else $error("result too early");

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(mixed_sample))
		else $error("result dropped");
endmodule

bind drum_and_tone_voice_mixer_core dtvm_chk u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.mixed_sample(out_ch.mixed_sample)
);
